>>> sv/sdm_pkg.sv
// shared types and constants for the dual generator sound mixer
`timescale 1ns / 1ps
`default_nettype none
package sdm_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned DAC_W    = 6;
  localparam int unsigned IDLE_W   = 8;
  localparam int unsigned BIT_TAPS = 8;
  localparam int unsigned BIT_PTR_W = 3;
  localparam int unsigned BIT_SUM_W = 8;
  localparam int unsigned DAC_SUM_W = 7;
  localparam int unsigned MIX_W    = 9;
  localparam int unsigned OUT_W    = 7;

  localparam logic [WORD_W-1:0] EV_BIT_ON  = 16'h8100;
  localparam logic [WORD_W-1:0] EV_BIT_OFF = 16'h8000;
  localparam logic [WORD_W-1:0] EV_NONE    = 16'hFFFF;

  localparam logic [BIT_W-1:0]     BIT_HIGH = 5'd31;
  localparam logic [BIT_SUM_W-1:0] BIT_MID  = 8'd120;
  localparam logic [DAC_SUM_W-1:0] DAC_MID  = 7'd62;

  // decoded event for one sample step
  typedef struct packed {
    logic step;
    logic bit_hit;
    logic bit_on;
    logic dac_hit;
    logic [DAC_W-1:0] dac_value;
  } sdm_evt_t;

endpackage
`default_nettype wire

>>> sv/dual_generator_sound_mixer.sv
// top level: input register, event decode, generator mix and result register
// an accepted word passes the input register and then the result register to out_valid
// throughput: one word per cycle unless out_stall holds the result register; the generator
// update lies on the path from the input register to the result register
// reset (rst, synchronous): sound off, levels, windows, pointers and idle counts
// cleared, both pipeline registers empty
`timescale 1ns / 1ps
`default_nettype none
module dual_generator_sound_mixer #(
  parameter int IDLE_LIMIT = 200
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          sound_enable,
  // event word input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sdm_pkg::WORD_W-1:0]    event_word,
  // sample output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sdm_pkg::OUT_W-1:0]          sample_out
);

  // enable register, written any time; only changed while idle by contract
  logic enable;

  // input register stage
  logic                       s1_valid;
  logic [sdm_pkg::WORD_W-1:0] s1_word;

  // handshake between stages
  logic out_free;
  logic fire;
  logic in_take;

  sdm_pkg::sdm_evt_t                 evt;
  logic [sdm_pkg::BIT_SUM_W-1:0]     bit_contrib;
  logic [sdm_pkg::DAC_SUM_W-1:0]     dac_contrib;
  logic [sdm_pkg::MIX_W-1:0]         mix;
  logic [sdm_pkg::OUT_W-1:0]         sample_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= sound_enable;
    end
  end

  // result register frees up when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word <= event_word;
    end
  end

  // decode the registered word; only advance generators when sound is on
  always_comb begin
    evt.step      = fire && enable;
    evt.bit_hit   = (s1_word == sdm_pkg::EV_BIT_ON) || (s1_word == sdm_pkg::EV_BIT_OFF);
    evt.bit_on    = (s1_word == sdm_pkg::EV_BIT_ON);
    evt.dac_hit   = !evt.bit_hit && (s1_word != sdm_pkg::EV_NONE);
    evt.dac_value = s1_word[sdm_pkg::DAC_W-1:0];
  end

  sdm_bit_gen #(
    .IDLE_LIMIT (IDLE_LIMIT)
  ) u_bit_gen (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .contrib (bit_contrib)
  );

  sdm_dac_gen #(
    .IDLE_LIMIT (IDLE_LIMIT)
  ) u_dac_gen (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .contrib (dac_contrib)
  );

  // mix both contributions and scale down by four
  always_comb begin
    mix = sdm_pkg::MIX_W'(bit_contrib) + sdm_pkg::MIX_W'(dac_contrib);
    sample_next = enable ? mix[sdm_pkg::MIX_W-1:2] : '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample_out <= sample_next;
    end
  end

`ifndef SYNTHESIS
  // input side only stalls while a word waits in the input register
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without a held word");

  // a word processed while sound is off gives silence
  a_silent_when_off: assert property (@(posedge clk) disable iff (rst)
    (fire && !enable) |=> (out_valid && sample_out == '0))
    else $error("nonzero sample while sound is off");

  // mixed sample never exceeds full scale
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out <= 7'd93))
    else $error("sample out of range");
`endif

endmodule
`default_nettype wire

>>> sv/sdm_bit_gen.sv
// 1-bit generator: level, 8-sample box window and idle counter
`timescale 1ns / 1ps
`default_nettype none
module sdm_bit_gen #(
  parameter int IDLE_LIMIT = 200
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sdm_pkg::sdm_evt_t               evt,
  output logic [sdm_pkg::BIT_SUM_W-1:0]        contrib
);

  localparam logic [sdm_pkg::IDLE_W-1:0] LIMIT = sdm_pkg::IDLE_W'(IDLE_LIMIT);

  logic [sdm_pkg::BIT_W-1:0]     level;
  logic [sdm_pkg::BIT_W-1:0]     level_next;
  logic [sdm_pkg::BIT_W-1:0]     window [sdm_pkg::BIT_TAPS];
  logic [sdm_pkg::BIT_W-1:0]     window_next [sdm_pkg::BIT_TAPS];
  logic [sdm_pkg::BIT_PTR_W-1:0] ptr;
  logic [sdm_pkg::BIT_PTR_W-1:0] ptr_next;
  logic [sdm_pkg::IDLE_W-1:0]    idle;
  logic [sdm_pkg::IDLE_W-1:0]    idle_eff;
  logic [sdm_pkg::IDLE_W-1:0]    idle_next;
  logic [sdm_pkg::BIT_SUM_W-1:0] sum;

  always_comb begin
    ptr_next   = ptr + 1'b1;
    level_next = level;
    idle_eff   = idle;
    if (evt.bit_hit) begin
      level_next = evt.bit_on ? sdm_pkg::BIT_HIGH : '0;
      idle_eff   = '0;
    end
    sum = '0;
    for (int k = 0; k < sdm_pkg::BIT_TAPS; k++) begin
      window_next[k] = (ptr_next == sdm_pkg::BIT_PTR_W'(k)) ? level_next : window[k];
      sum = sum + sdm_pkg::BIT_SUM_W'(window_next[k]);
    end
    idle_next = (idle_eff < LIMIT) ? idle_eff + 1'b1 : idle_eff;
    contrib   = (idle_eff < LIMIT) ? sum : sdm_pkg::BIT_MID;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      ptr   <= '0;
      idle  <= '0;
      for (int k = 0; k < sdm_pkg::BIT_TAPS; k++) window[k] <= '0;
    end else if (evt.step) begin
      level <= level_next;
      ptr   <= ptr_next;
      idle  <= idle_next;
      for (int k = 0; k < sdm_pkg::BIT_TAPS; k++) window[k] <= window_next[k];
    end
  end

endmodule
`default_nettype wire

>>> sv/sdm_dac_gen.sv
// 6-bit dac generator: level, 2-sample box window and idle counter
`timescale 1ns / 1ps
`default_nettype none
module sdm_dac_gen #(
  parameter int IDLE_LIMIT = 200
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire sdm_pkg::sdm_evt_t               evt,
  output logic [sdm_pkg::DAC_SUM_W-1:0]        contrib
);

  localparam logic [sdm_pkg::IDLE_W-1:0] LIMIT = sdm_pkg::IDLE_W'(IDLE_LIMIT);

  logic [sdm_pkg::DAC_W-1:0]  level;
  logic [sdm_pkg::DAC_W-1:0]  level_next;
  logic [sdm_pkg::DAC_W-1:0]  tap0;
  logic [sdm_pkg::DAC_W-1:0]  tap1;
  logic [sdm_pkg::DAC_W-1:0]  tap0_next;
  logic [sdm_pkg::DAC_W-1:0]  tap1_next;
  logic                       ptr;
  logic                       ptr_next;
  logic [sdm_pkg::IDLE_W-1:0] idle;
  logic [sdm_pkg::IDLE_W-1:0] idle_eff;
  logic [sdm_pkg::IDLE_W-1:0] idle_next;

  always_comb begin
    ptr_next   = ~ptr;
    level_next = evt.dac_hit ? evt.dac_value : level;
    idle_eff   = evt.dac_hit ? '0 : idle;
    tap0_next  = ptr_next ? tap0 : level_next;
    tap1_next  = ptr_next ? level_next : tap1;
    idle_next  = (idle_eff < LIMIT) ? idle_eff + 1'b1 : idle_eff;
    contrib    = (idle_eff < LIMIT)
               ? sdm_pkg::DAC_SUM_W'(tap0_next) + sdm_pkg::DAC_SUM_W'(tap1_next)
               : sdm_pkg::DAC_MID;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      tap0  <= '0;
      tap1  <= '0;
      ptr   <= 1'b0;
      idle  <= '0;
    end else if (evt.step) begin
      level <= level_next;
      tap0  <= tap0_next;
      tap1  <= tap1_next;
      ptr   <= ptr_next;
      idle  <= idle_next;
    end
  end

endmodule
`default_nettype wire
